>>> sv/coordinate_bucket_hash_unit_assert.svh
// assertion macros for the coordinate bucket hash unit
// the enclosing module supplies clk and arst_n
`ifndef COORDINATE_BUCKET_HASH_UNIT_ASSERT_SVH
`define COORDINATE_BUCKET_HASH_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define CBH_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cbh assertion failed");

// next-cycle implication
`define CBH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cbh assertion failed");

`else

`define CBH_ASSERT_IMPL(lbl, ante, cons)
`define CBH_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> sv/cbh_pkg.sv
`default_nettype none

package cbh_pkg;

	localparam int COORD_W    = 16;
	localparam int NUM_COORDS = 8;
	localparam int KEY_W      = 32;
	localparam int TS_W       = 31;
	localparam int IDX_W      = 30;
	localparam int SHIFT_W    = 5;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	// remainder steps per pipeline stage
	localparam int MOD_STEPS  = 4;
	localparam int MOD_STAGES = KEY_W / MOD_STEPS;

	localparam logic [CFG_IDX_W-1:0] REG_HASH_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_AMOUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE   = 2'd2;

	typedef enum logic [MODE_W-1:0] {
		MODE_FULL_Z   = 2'd0,
		MODE_PART_Z   = 2'd1,
		MODE_FULL_SUM = 2'd2,
		MODE_PART_SUM = 2'd3
	} hash_mode_t;

	// key bits still to be consumed (msb first) and partial remainder
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TS_W-1:0]  rem;
	} mod_lane_t;

endpackage

`default_nettype wire

>>> sv/cbh_mod_stage.sv
`default_nettype none

module cbh_mod_stage #(
	parameter int STEPS = 4
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [cbh_pkg::TS_W-1:0] divisor,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire cbh_pkg::mod_lane_t       in_lane,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output cbh_pkg::mod_lane_t            out_lane
);

	cbh_pkg::mod_lane_t               lane_d;
	cbh_pkg::mod_lane_t               lane_s;
	logic                             valid_s;
	logic [cbh_pkg::KEY_W-1:0]        trial;

	assign in_ready  = !valid_s || out_ready;
	assign out_valid = valid_s;
	assign out_lane  = lane_s;

	// restoring remainder, one key bit per step
	always_comb begin
		lane_d = in_lane;
		trial  = '0;
		for (int s = 0; s < STEPS; s++) begin
			trial      = {lane_d.rem, lane_d.key[cbh_pkg::KEY_W-1]};
			lane_d.key = {lane_d.key[cbh_pkg::KEY_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				trial = trial - {1'b0, divisor};
			end
			lane_d.rem = trial[cbh_pkg::TS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (in_ready) begin
			valid_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			lane_s <= lane_d;
		end
	end

endmodule

`default_nettype wire

>>> sv/coordinate_bucket_hash_unit.sv
// Coordinate bucket hash unit: forms a key from up to eight coordinates
// (full or partial Z-order interleave, or full or partial sum, chosen by
// hash_mode), shifts it right by shift_amount, keeps 32 bits and returns
// the key modulo table_size (0 when table_size is 0). One request is taken
// every clock cycle, also with a full output register, until out_ready
// has held it long enough to fill the pipeline. Each request passes the
// key stage, the shift stage, eight remainder stages of four restoring
// steps each (32 key bits) and the output register. The user must write
// configuration (cfg_we/cfg_index/cfg_data) only while idle; unenforced.
`default_nettype none
`include "coordinate_bucket_hash_unit_assert.svh"

module coordinate_bucket_hash_unit #(
	parameter int DIMENSIONS = 8,
	parameter int COORD_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [cbh_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [cbh_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [cbh_pkg::COORD_W-1:0]        coord_0,
	input  wire logic [cbh_pkg::COORD_W-1:0]        coord_1,
	input  wire logic [cbh_pkg::COORD_W-1:0]        coord_2,
	input  wire logic [cbh_pkg::COORD_W-1:0]        coord_3,
	input  wire logic [cbh_pkg::COORD_W-1:0]        coord_4,
	input  wire logic [cbh_pkg::COORD_W-1:0]        coord_5,
	input  wire logic [cbh_pkg::COORD_W-1:0]        coord_6,
	input  wire logic [cbh_pkg::COORD_W-1:0]        coord_7,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [cbh_pkg::IDX_W-1:0]               bucket_index
);

	localparam int CB = (COORD_BITS < cbh_pkg::COORD_W) ? COORD_BITS : cbh_pkg::COORD_W;
	localparam int FULL_W = DIMENSIONS * CB;
	localparam int RAW_W = (FULL_W > cbh_pkg::KEY_W) ? FULL_W : cbh_pkg::KEY_W;
	localparam int SUM_W = CB + 3;
	localparam int MOD_STAGES = cbh_pkg::MOD_STAGES;

	// configuration
	cbh_pkg::hash_mode_t                 hash_mode_q;
	logic [cbh_pkg::SHIFT_W-1:0]         shift_amount_q;
	logic [cbh_pkg::TS_W-1:0]            table_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_mode_q    <= cbh_pkg::MODE_FULL_Z;
			shift_amount_q <= '0;
			table_size_q   <= cbh_pkg::TS_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				cbh_pkg::REG_HASH_MODE: begin
					hash_mode_q <= cbh_pkg::hash_mode_t'(cfg_data[cbh_pkg::MODE_W-1:0]);
				end
				cbh_pkg::REG_SHIFT_AMOUNT: begin
					shift_amount_q <= cfg_data[cbh_pkg::SHIFT_W-1:0];
				end
				cbh_pkg::REG_TABLE_SIZE: begin
					table_size_q <= cfg_data[cbh_pkg::TS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// stage 1: raw key
	logic [CB-1:0]               coord_m [cbh_pkg::NUM_COORDS];
	logic [RAW_W-1:0]            full_z;
	logic [cbh_pkg::KEY_W-1:0]   part_z;
	logic [SUM_W-1:0]            sum_full;
	logic [SUM_W-1:0]            sum_part;
	logic [RAW_W-1:0]            raw_d;
	logic [RAW_W-1:0]            raw_s1;
	logic                        v_s1;
	logic                        rdy_s1;

	assign coord_m[0] = coord_0[CB-1:0];
	assign coord_m[1] = coord_1[CB-1:0];
	assign coord_m[2] = coord_2[CB-1:0];
	assign coord_m[3] = coord_3[CB-1:0];
	assign coord_m[4] = coord_4[CB-1:0];
	assign coord_m[5] = coord_5[CB-1:0];
	assign coord_m[6] = coord_6[CB-1:0];
	assign coord_m[7] = coord_7[CB-1:0];

	always_comb begin
		full_z   = '0;
		part_z   = '0;
		sum_full = '0;
		for (int i = 0; i < CB; i++) begin
			for (int j = 0; j < DIMENSIONS; j++) begin
				full_z[i*DIMENSIONS + j] = coord_m[j][i];
			end
			part_z[i*2]     = coord_m[0][i];
			part_z[i*2 + 1] = coord_m[1][i];
		end
		for (int j = 0; j < DIMENSIONS; j++) begin
			sum_full = sum_full + SUM_W'(coord_m[j]);
		end
		sum_part = SUM_W'(coord_m[0]) + SUM_W'(coord_m[1]);
		case (hash_mode_q)
			cbh_pkg::MODE_FULL_Z:   raw_d = full_z;
			cbh_pkg::MODE_PART_Z:   raw_d = RAW_W'(part_z);
			cbh_pkg::MODE_FULL_SUM: raw_d = RAW_W'(sum_full);
			cbh_pkg::MODE_PART_SUM: raw_d = RAW_W'(sum_part);
			default:                raw_d = '0;
		endcase
	end

	// stage 2: shifted 32-bit key
	logic [RAW_W-1:0]            shifted;
	logic [cbh_pkg::KEY_W-1:0]   key_s2;
	logic                        v_s2;
	logic                        rdy_s2;

	assign shifted = raw_s1 >> shift_amount_q;

	// remainder chain
	cbh_pkg::mod_lane_t          lane [MOD_STAGES+1];
	logic [MOD_STAGES:0]         mod_vld;
	logic [MOD_STAGES:0]         mod_rdy;

	assign in_ready = rdy_s1;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign rdy_s2   = !v_s2 || mod_rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			raw_s1 <= raw_d;
		end
		if (v_s1 && rdy_s2) begin
			key_s2 <= shifted[cbh_pkg::KEY_W-1:0];
		end
	end

	assign mod_vld[0] = v_s2;
	assign lane[0].key = key_s2;
	assign lane[0].rem = '0;

	for (genvar k = 0; k < MOD_STAGES; k++) begin : g_mod
		cbh_mod_stage #(
			.STEPS(cbh_pkg::MOD_STEPS)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.divisor  (table_size_q),
			.in_valid (mod_vld[k]),
			.in_ready (mod_rdy[k]),
			.in_lane  (lane[k]),
			.out_valid(mod_vld[k+1]),
			.out_ready(mod_rdy[k+1]),
			.out_lane (lane[k+1])
		);
	end

	// output register
	logic                        out_valid_q;
	logic [cbh_pkg::IDX_W-1:0]   bucket_q;

	assign mod_rdy[MOD_STAGES] = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign bucket_index = bucket_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (mod_rdy[MOD_STAGES]) begin
			out_valid_q <= mod_vld[MOD_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (mod_vld[MOD_STAGES] && mod_rdy[MOD_STAGES]) begin
			// zero table size maps everything to bucket 0
			bucket_q <= (table_size_q == '0) ? '0 : lane[MOD_STAGES].rem[cbh_pkg::IDX_W-1:0];
		end
	end

	`CBH_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, v_s1)
	`CBH_ASSERT_NEXT(a_s2_holds_on_stall, v_s2 && !mod_rdy[0], v_s2 && $stable(key_s2))
	`CBH_ASSERT_IMPL(a_out_from_chain, $rose(out_valid_q), $past(mod_vld[MOD_STAGES]))

endmodule

`default_nettype wire
